// File: sv/pwcr_pkg.sv
package pwcr_pkg;

    // Code geometry
    localparam int BYTE_W     = 8;
    localparam int CODE_BYTES = 5;
    localparam int CODE_W     = BYTE_W * CODE_BYTES;
    localparam int BIT_IDX_W  = 3;
    localparam int BYTE_IDX_W = 3;
    localparam int LIMIT_W    = 16;
    localparam int MBYTES_W   = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Stream payload widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0]  RST_WIDTH_MIN   = 16'd400;
    localparam logic [LIMIT_W-1:0]  RST_WIDTH_MAX   = 16'd1500;
    localparam logic [LIMIT_W-1:0]  RST_ONE_LIMIT   = 16'd750;
    localparam logic [CODE_W-1:0]   RST_MATCH_CODE  = '0;
    localparam logic [MBYTES_W-1:0] RST_MATCH_BYTES = 3'd5;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_MIN   = 3'd0,
        REG_WIDTH_MAX   = 3'd1,
        REG_ONE_LIMIT   = 3'd2,
        REG_MATCH_CODE  = 3'd3,
        REG_MATCH_BYTES = 3'd4
    } reg_idx_t;

    // Classified tick, handed from the front to the back
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ABORT = 2'd1,
        OP_BIT   = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     bit_val;
    } pwcr_op_t;

    localparam int OP_W = $bits(pwcr_op_t);

endpackage

// File: sv/pulse_width_code_receiver_core.sv
// Channel | Direction | Beat contents
// s_      | in        | one timing tick: s_tdata[0] pin_level
// m_      | out       | one result per tick: new_code, last_code, code_match
// cfg_    | in        | register write: cfg_index selects, cfg_data carries value
//
// One tick is accepted per cycle while s_tready is high and gives exactly one
// result beat. A tick is classified into the queue, then the code shifter
// writes the output register. Reset is synchronous on aresetn low.
// A stalled m_ side fills the QUEUE_DEPTH queue before s_tready drops.
module pulse_width_code_receiver_core import pwcr_pkg::*; #(
    parameter int TIMER_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] pin_level
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] new_code, [40:1] last_code,
                                             // [41] code_match
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0]  width_min_reg;
    logic [LIMIT_W-1:0]  width_max_reg;
    logic [LIMIT_W-1:0]  one_limit_reg;
    logic [CODE_W-1:0]   match_code_reg;
    logic [MBYTES_W-1:0] match_bytes_reg;

    logic                s_accept;
    pwcr_op_t            front_op;
    logic                q_full, q_empty, q_pop;
    pwcr_op_t            q_head;
    logic                res_new_code, res_code_match;
    logic [CODE_W-1:0]   res_last_code;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_min_reg   <= RST_WIDTH_MIN;
            width_max_reg   <= RST_WIDTH_MAX;
            one_limit_reg   <= RST_ONE_LIMIT;
            match_code_reg  <= RST_MATCH_CODE;
            match_bytes_reg <= RST_MATCH_BYTES;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH_MIN:   width_min_reg   <= cfg_data[LIMIT_W-1:0];
                REG_WIDTH_MAX:   width_max_reg   <= cfg_data[LIMIT_W-1:0];
                REG_ONE_LIMIT:   one_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_MATCH_CODE:  match_code_reg  <= cfg_data[CODE_W-1:0];
                REG_MATCH_BYTES: match_bytes_reg <= cfg_data[MBYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    pwcr_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_valid (s_accept),
        .pin_level  (s_tdata[0]),
        .width_min  (width_min_reg),
        .width_max  (width_max_reg),
        .one_limit  (one_limit_reg),
        .op         (front_op)
    );

    pwcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_accept),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head_op (q_head)
    );

    pwcr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op_valid       (!q_empty),
        .op             (q_head),
        .op_take        (q_pop),
        .match_code     (match_code_reg),
        .match_bytes    (match_bytes_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_new_code   (res_new_code),
        .out_last_code  (res_last_code),
        .out_code_match (res_code_match)
    );

    // Pack the result beat, zero fill to whole bytes
    assign m_tdata = {{(M_TDATA_W - CODE_W - 2){1'b0}},
                      res_code_match, res_last_code, res_new_code};

endmodule

// File: sv/pwcr_front.sv
module pwcr_front import pwcr_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick_valid,
    input  logic               pin_level,
    input  logic [LIMIT_W-1:0] width_min,
    input  logic [LIMIT_W-1:0] width_max,
    input  logic [LIMIT_W-1:0] one_limit,
    output pwcr_op_t           op
);

    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] count_reg, count_next;
    logic                  prev_reg, prev_next;
    logic [TIMER_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      width_x, min_x, max_x, one_x;

    // Saturating tick count since the last edge
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

    assign width_x = CMP_W'(count_inc);
    assign min_x   = CMP_W'(width_min);
    assign max_x   = CMP_W'(width_max);
    assign one_x   = CMP_W'(one_limit);

    // Classify the beat: edge inside the window is a data bit, outside it an abort
    always_comb begin
        count_next  = count_reg;
        prev_next   = prev_reg;
        op.kind     = OP_NONE;
        op.bit_val  = 1'b0;
        if (tick_valid) begin
            count_next = count_inc;
            if (pin_level != prev_reg) begin
                count_next = '0;
                prev_next  = pin_level;
                if ((width_x > max_x) || (width_x < min_x)) begin
                    op.kind = OP_ABORT;
                end else begin
                    op.kind    = OP_BIT;
                    op.bit_val = (width_x < one_x);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            prev_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

// File: sv/pwcr_queue.sv
module pwcr_queue import pwcr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  pwcr_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output pwcr_op_t head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    pwcr_op_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: sv/pwcr_back.sv
module pwcr_back import pwcr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                op_valid,
    input  pwcr_op_t            op,
    output logic                op_take,
    input  logic [CODE_W-1:0]   match_code,
    input  logic [MBYTES_W-1:0] match_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_new_code,
    output logic [CODE_W-1:0]   out_last_code,
    output logic                out_code_match
);

    localparam logic [BIT_IDX_W-1:0]  BIT_LAST  = BIT_IDX_W'(BYTE_W - 1);
    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST = BYTE_IDX_W'(CODE_BYTES - 1);

    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [CODE_W-1:0]     shift_reg, shift_next;
    logic [CODE_W-1:0]     held_reg, held_next;
    logic                  fresh;
    logic [CODE_W-1:0]     shifted;
    logic [CODE_W-1:0]     sel_mask;
    logic                  match;

    logic                  valid_reg;
    logic                  new_code_reg;
    logic [CODE_W-1:0]     last_code_reg;
    logic                  match_reg;

    // Take a beat when the output slot is free or drains this cycle
    assign op_take = op_valid && (!valid_reg || out_ready);

    assign shifted = {shift_reg[CODE_W-2:0], op.bit_val};

    // Collect bits, latch the code after the last byte, clear on an abort
    always_comb begin
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        held_next     = held_reg;
        fresh         = 1'b0;
        case (op.kind)
            OP_ABORT: begin
                bit_idx_next  = '0;
                byte_idx_next = '0;
                shift_next    = '0;
            end
            OP_BIT: begin
                shift_next   = shifted;
                bit_idx_next = bit_idx_reg + 1'b1;
                if (bit_idx_reg == BIT_LAST) begin
                    bit_idx_next  = '0;
                    byte_idx_next = byte_idx_reg + 1'b1;
                    if (byte_idx_reg == BYTE_LAST) begin
                        held_next     = shifted;
                        fresh         = 1'b1;
                        byte_idx_next = '0;
                        shift_next    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Compare the leading bytes; zero bytes always match
    always_comb begin
        sel_mask = '0;
        for (int i = 0; i < CODE_BYTES; i++) begin
            sel_mask[CODE_W-1-BYTE_W*i -: BYTE_W] =
                (i < int'(match_bytes)) ? {BYTE_W{1'b1}} : {BYTE_W{1'b0}};
        end
        match = ((held_next & sel_mask) == (match_code & sel_mask));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            shift_reg    <= '0;
            held_reg     <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (op_take) begin
                bit_idx_reg  <= bit_idx_next;
                byte_idx_reg <= byte_idx_next;
                shift_reg    <= shift_next;
                held_reg     <= held_next;
                valid_reg    <= 1'b1;
            end else if (out_ready) begin
                valid_reg    <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (op_take) begin
            new_code_reg  <= fresh;
            last_code_reg <= held_next;
            match_reg     <= match;
        end
    end

    assign out_valid      = valid_reg;
    assign out_new_code   = new_code_reg;
    assign out_last_code  = last_code_reg;
    assign out_code_match = match_reg;

endmodule

// File: dv/pulse_width_code_receiver_core_tb.sv
module pulse_width_code_receiver_core_tb;
    import pwcr_pkg::*;

    localparam int TICK_W       = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_TICKS = 80;

    // One result beat as the decoder should produce it
    typedef struct {
        logic              new_code;
        logic [CODE_W-1:0] last_code;
        logic              code_match;
    } tick_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [0] pin_level
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [0] new_code, [40:1] last_code, [41] code_match
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies kept in step with every accepted write
    logic [LIMIT_W-1:0]  win_min   = RST_WIDTH_MIN;
    logic [LIMIT_W-1:0]  win_max   = RST_WIDTH_MAX;
    logic [LIMIT_W-1:0]  one_lim   = RST_ONE_LIMIT;
    logic [CODE_W-1:0]   match_ref = RST_MATCH_CODE;
    logic [MBYTES_W-1:0] match_len = RST_MATCH_BYTES;

    // Decoder state as seen from the pin
    logic              line_prev    = 1'b0;
    logic [TICK_W-1:0] run_len      = '0;
    int                bits_in_byte = 0;
    int                bytes_done   = 0;
    logic [CODE_W-1:0] shift_reg    = '0;
    logic [CODE_W-1:0] held_reg     = '0;

    tick_result_t      pending_results[$];
    int                mismatch_count = 0;
    int unsigned       ticks_sent     = 0;
    int                quiet_cycles   = 0;
    logic              line_level     = 1'b0;
    logic [CODE_W-1:0] last_code_sent = '0;
    bit                s_gaps_on      = 1'b1;
    bit                m_stalls_on    = 1'b1;
    bit                hold_request   = 1'b0;

    pulse_width_code_receiver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bytes of the code that take part in the compare, leading byte first
    function automatic logic [CODE_W-1:0] match_select(input logic [MBYTES_W-1:0] n);
        logic [CODE_W-1:0] full;
        full = '1;
        if (n >= CODE_BYTES)
            return full;
        return full & ~(full >> (BYTE_W * n));
    endfunction

    // Advance the decoder by one tick and queue the beat it owes
    function automatic void decode_tick(input logic level);
        tick_result_t      r;
        logic [TICK_W-1:0] w;
        logic [CODE_W-1:0] sel;
        r.new_code = 1'b0;
        if (run_len != '1)
            run_len = run_len + 1'b1;
        if (level != line_prev) begin
            w         = run_len;
            run_len   = '0;
            line_prev = level;
            if (w > win_max || w < win_min) begin
                bits_in_byte = 0;
                bytes_done   = 0;
                shift_reg    = '0;
            end else begin
                shift_reg    = {shift_reg[CODE_W-2:0], (w < one_lim)};
                bits_in_byte = bits_in_byte + 1;
                if (bits_in_byte >= BYTE_W) begin
                    bits_in_byte = 0;
                    bytes_done   = bytes_done + 1;
                    if (bytes_done >= CODE_BYTES) begin
                        held_reg   = shift_reg;
                        r.new_code = 1'b1;
                        bytes_done = 0;
                        shift_reg  = '0;
                    end
                end
            end
        end
        sel          = match_select(match_len);
        r.last_code  = held_reg;
        r.code_match = ((held_reg & sel) == (match_ref & sel));
        pending_results.push_back(r);
    endfunction

    // Offer one tick, with an occasional gap in front of it
    task automatic send_tick(input logic level);
        if (s_gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, level};
        do @(posedge aclk); while (!s_tready);
        decode_tick(level);
        ticks_sent++;
    endtask

    // Flip the pin and hold it for the given number of ticks
    task automatic send_pulse(input int width);
        line_level = !line_level;
        repeat (width) send_tick(line_level);
    endtask

    // Abort any partial code, send the leading bits MSB first, close the last pulse
    task automatic send_code(input logic [CODE_W-1:0] code, input int nbits);
        int w;
        if (win_min > 1)
            send_pulse(1);
        else
            send_pulse(int'(win_max) + 1);
        for (int i = CODE_W - 1; i >= CODE_W - nbits; i--) begin
            if (code[i])
                w = $urandom_range(win_min, one_lim - 1);
            else
                w = $urandom_range(one_lim, win_max);
            send_pulse(w);
        end
        send_pulse(1);
    endtask

    // Drop the tick stream and wait until every owed beat is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Write one register while idle; junk fills the bits above its width
    task automatic set_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] beat;
        wait_drained();
        beat = CFG_DATA_W'({$urandom, $urandom});
        case (idx)
            REG_WIDTH_MIN, REG_WIDTH_MAX, REG_ONE_LIMIT: beat[LIMIT_W-1:0] = value[LIMIT_W-1:0];
            REG_MATCH_BYTES: beat[MBYTES_W-1:0] = value[MBYTES_W-1:0];
            default: beat = value;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= beat;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH_MIN:   win_min   = beat[LIMIT_W-1:0];
            REG_WIDTH_MAX:   win_max   = beat[LIMIT_W-1:0];
            REG_ONE_LIMIT:   one_lim   = beat[LIMIT_W-1:0];
            REG_MATCH_CODE:  match_ref = beat[CODE_W-1:0];
            REG_MATCH_BYTES: match_len = beat[MBYTES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_window(input int lo, input int hi, input int one);
        set_register(REG_WIDTH_MIN, CFG_DATA_W'(lo));
        set_register(REG_WIDTH_MAX, CFG_DATA_W'(hi));
        set_register(REG_ONE_LIMIT, CFG_DATA_W'(one));
    endtask

    // Idle pin after reset: zero held code against the zero match code
    task automatic test_after_reset();
        repeat (5) send_tick(1'b0);
    endtask

    task automatic test_small_window_codes();
        program_window(1, 3, 2);
        send_code(40'hAA_55_AA_55_AA, CODE_W);
    endtask

    // Sweep the compare length over a code that differs only in its last byte
    task automatic test_match_length();
        send_code(40'h12_34_56_78_9A, CODE_W);
        set_register(REG_MATCH_CODE, 40'h12_34_56_78_00);
        for (int n = 0; n < 8; n++) begin
            set_register(REG_MATCH_BYTES, CFG_DATA_W'(n));
            send_tick(line_level);
        end
        set_register(REG_MATCH_CODE, 40'h12_34_56_78_9A);
        set_register(REG_MATCH_BYTES, CFG_DATA_W'(CODE_BYTES));
        send_tick(line_level);
        set_register(REG_MATCH_CODE, 40'hFF_34_56_78_9A);
        set_register(REG_MATCH_BYTES, CFG_DATA_W'(1));
        send_tick(line_level);
    endtask

    // Open window with all-zero and all-one decisions, then an empty window
    task automatic test_window_extremes();
        program_window(0, 65535, 0);
        repeat (41) send_pulse($urandom_range(1, 2));
        set_register(REG_ONE_LIMIT, CFG_DATA_W'(65535));
        repeat (41) send_pulse($urandom_range(1, 2));
        program_window(65535, 0, 32768);
        repeat (6) send_pulse($urandom_range(1, 2));
    endtask

    // Hold the result side off long enough to back the ticks up
    task automatic test_output_stall();
        program_window(1, 2, 2);
        hold_request = 1'b1;
        send_code(CODE_W'({$urandom, $urandom}), CODE_W);
    endtask

    task automatic random_window();
        int lo;
        int one;
        lo  = $urandom_range(1, 3);
        one = lo + $urandom_range(1, 2);
        program_window(lo, one + $urandom_range(0, 3), one);
    endtask

    // Mostly whole codes with random content, some cut short, some noise
    task automatic test_random_traffic();
        int unsigned       start_ticks;
        int unsigned       pick;
        logic [CODE_W-1:0] code;
        start_ticks = ticks_sent;
        random_window();
        while (ticks_sent - start_ticks < RANDOM_TICKS) begin
            if ($urandom_range(0, 3) == 0)
                random_window();
            if ($urandom_range(0, 3) == 0) begin
                set_register(REG_MATCH_CODE, $urandom_range(0, 1) ?
                             last_code_sent : CODE_W'({$urandom, $urandom}));
                set_register(REG_MATCH_BYTES, CFG_DATA_W'($urandom_range(0, 7)));
            end
            pick = $urandom_range(0, 9);
            code = CODE_W'({$urandom, $urandom});
            if (pick <= 6) begin
                send_code(code, CODE_W);
                last_code_sent = code;
            end else if (pick == 7) begin
                send_code(code, $urandom_range(1, CODE_W - 1));
            end else begin
                repeat ($urandom_range(1, 8)) send_pulse($urandom_range(1, int'(win_max) + 3));
            end
        end
    endtask

    // Run out at full rate on both sides
    task automatic test_no_idle_tail();
        s_gaps_on   = 1'b0;
        m_stalls_on = 1'b0;
        program_window(2, 5, 3);
        set_register(REG_MATCH_BYTES, CFG_DATA_W'(2));
        send_code(CODE_W'({$urandom, $urandom}), CODE_W);
    endtask

    // Result side: random stall bursts, plus one long hold on request
    initial begin : ready_drive
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (m_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest owed one
    always @(posedge aclk) begin : result_check
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none owed: actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.new_code) begin
                    $display("%0t: new_code expected %0b actual %0b",
                             $time, want.new_code, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[CODE_W:1] !== want.last_code) begin
                    $display("%0t: last_code expected %h actual %h",
                             $time, want.last_code, m_tdata[CODE_W:1]);
                    mismatch_count++;
                end
                if (m_tdata[CODE_W+1] !== want.code_match) begin
                    $display("%0t: code_match expected %0b actual %0b",
                             $time, want.code_match, m_tdata[CODE_W+1]);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if no beat moves on any channel for too long
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main_seq
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WIDTH_MIN;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_small_window_codes();
        test_match_length();
        test_window_extremes();
        test_output_stall();
        test_random_traffic();
        test_no_idle_tail();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
